/* rtl/pipct_pkg.sv */
// Shared constants, codes and types of the point-in-polygon crossing test.
`timescale 1ns / 1ps

package pipct_pkg;

   // coordinate and arithmetic widths
   localparam int COORD_BITS    = 24;
   localparam int REL_BITS      = COORD_BITS + 1;
   localparam int PROD_BITS     = 2 * REL_BITS;
   localparam int DIFF_BITS     = PROD_BITS + 1;
   localparam int NEAR_BITS     = 24;
   localparam int MAG_EXT_BITS  = (COORD_BITS > NEAR_BITS) ? COORD_BITS : NEAR_BITS;
   localparam int SQ_BITS       = 2 * NEAR_BITS;
   localparam int SUM_BITS      = SQ_BITS + 1;
   localparam int NEAR_SQ_BITS  = 48;

   // register port
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_IDX_BITS  = CSR_ADDR_BITS - 3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IDX_NEAR = '0;
   localparam logic [NEAR_SQ_BITS-1:0] NEAR_SQ_RESET = NEAR_SQ_BITS'(1);

   // verdict codes; early code shares them, with zero meaning undecided
   localparam logic [2:0] VERDICT_EVEN       = 3'd0;
   localparam logic [2:0] VERDICT_ODD        = 3'd1;
   localparam logic [2:0] VERDICT_EDGE       = 3'd2;
   localparam logic [2:0] VERDICT_NEAR       = 3'd3;
   localparam logic [2:0] VERDICT_DEGENERATE = 3'd4;
   localparam logic [2:0] EARLY_NONE         = 3'd0;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] vertex_x;
      logic signed [COORD_BITS-1:0] vertex_y;
      logic signed [COORD_BITS-1:0] query_x;
      logic signed [COORD_BITS-1:0] query_y;
      logic                         last_vertex;
      logic                         empty_polygon;
   } req_type;

   typedef struct packed {
      logic       inside_res;
      logic [2:0] verdict;
   } rsp_type;

   // vertex relative to the query point, with its squared distance
   typedef struct packed {
      logic signed [REL_BITS-1:0] cx;
      logic signed [REL_BITS-1:0] cy;
      logic [SUM_BITS-1:0]        dist_sq;
      logic                       out_of_range;
      logic                       last;
      logic                       empty;
   } rel_type;

   // cross products against previous and first vertex
   typedef struct packed {
      logic                        last;
      logic                        empty;
      logic                        has_prev;
      logic signed [PROD_BITS-1:0] pp;
      logic signed [PROD_BITS-1:0] pq;
      logic signed [PROD_BITS-1:0] fq;
      logic signed [PROD_BITS-1:0] fr;
      logic signed [REL_BITS-1:0]  cy;
      logic signed [REL_BITS-1:0]  prev_y;
      logic signed [REL_BITS-1:0]  first_y;
      logic [SUM_BITS-1:0]         dist_sq;
      logic                        out_of_range;
      logic [SUM_BITS-1:0]         prev_dist_sq;
      logic                        prev_out_of_range;
   } prod_type;

endpackage

/* rtl/point_in_polygon_crossing_test_top.sv */
// Top level of the point-in-polygon ray crossing test.
`timescale 1ns / 1ps

// Point-in-polygon crossing test. Feed one request per polygon vertex, each
// carrying the query point; the request marked last_vertex closes the wrap
// edge and yields one response, a request with empty_polygon yields an
// outside response at once and drops any unfinished polygon. Other requests
// yield nothing. One request is taken every clock cycle while the pipe moves;
// a closing request passes s1_ff, s2_ff, s3_ff and rsp_ff to rsp_valid. The
// work runs in three registered steps: relative coordinates and squared
// distance, then the four cross products against the previous and first
// vertex, then sign tests, parity and early-verdict update. The running
// polygon state lives at the second and third step, so one vertex depends
// on the one before it without a bubble. The response register lets a new
// request in while a response waits; only a response that meets a full,
// stalled output register holds the pipe. near_distance_squared sits at
// byte address 0 (64-bit data, low 48 bits used, reset 1). Write it only
// while no polygon work is in flight; the block does not enforce this.
module point_in_polygon_crossing_test_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  pipct_pkg::req_type                      req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output pipct_pkg::rsp_type                      rsp_data,
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [pipct_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [pipct_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [pipct_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                    csr_pready
);

   localparam int REL_BITS   = pipct_pkg::REL_BITS;
   localparam int COORD_BITS = pipct_pkg::COORD_BITS;
   localparam int DIFF_BITS  = pipct_pkg::DIFF_BITS;
   localparam int SUM_BITS   = pipct_pkg::SUM_BITS;
   localparam int SQ_BITS    = pipct_pkg::SQ_BITS;
   localparam int NEAR_BITS  = pipct_pkg::NEAR_BITS;
   localparam int MAG_BITS   = pipct_pkg::MAG_EXT_BITS;

   // magnitude of a relative coordinate; it always fits the coordinate width
   function automatic logic [COORD_BITS-1:0] mag_of(input logic signed [REL_BITS-1:0] v);
      logic [REL_BITS-1:0] t;
      t = v[REL_BITS-1] ? REL_BITS'(-v) : REL_BITS'(v);
      return t[COORD_BITS-1:0];
   endfunction

   function automatic logic near_hit(input logic [SUM_BITS-1:0] d,
                                     input logic oor,
                                     input logic [pipct_pkg::NEAR_SQ_BITS-1:0] thr);
      return !oor && (SUM_BITS'(thr) > d);
   endfunction

   // {right, left} ray crossings of edge a->b; sn is the sign carrier of bx*ay - ax*by
   function automatic logic [1:0] crossings(input logic signed [DIFF_BITS-1:0] sn,
                                            input logic signed [REL_BITS-1:0] ay,
                                            input logic signed [REL_BITS-1:0] by);
      logic sd_pos, sn_zero, sn_pos, rgt, lft;
      sd_pos  = ay > by;
      sn_zero = sn == '0;
      sn_pos  = !sn[DIFF_BITS-1] && !sn_zero;
      rgt = ((by > 0) != (ay > 0)) && (sn_zero || (sn_pos == sd_pos));
      lft = ((by < 0) != (ay < 0)) && (sn_zero || (sn_pos != sd_pos));
      return {rgt, lft};
   endfunction

   // ---------------------------------------------------------------- config
   logic [pipct_pkg::NEAR_SQ_BITS-1:0] near_ff, near_in;
   logic [pipct_pkg::CSR_IDX_BITS-1:0] csr_idx;

   assign csr_idx    = csr_paddr[pipct_pkg::CSR_ADDR_BITS-1:3];
   assign csr_pready = 1'b1;

   always_comb begin
      near_in = near_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          csr_idx == pipct_pkg::CSR_IDX_NEAR) begin
         near_in = csr_pwdata[pipct_pkg::NEAR_SQ_BITS-1:0];
      end
   end

   assign csr_prdata = (csr_idx == pipct_pkg::CSR_IDX_NEAR) ?
                       pipct_pkg::CSR_DATA_BITS'(near_ff) : '0;

   // ---------------------------------------------------------------- flow
   // whole pipe moves together; it holds only for a response that cannot land
   logic                  advance;
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s2_valid_ff, s2_valid_in;
   logic                  s3_valid_ff, s3_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   pipct_pkg::req_type    s1_ff, s1_in;
   pipct_pkg::rel_type    s2_ff, s2_in;
   pipct_pkg::prod_type   s3_ff, s3_in;
   pipct_pkg::rsp_type    rsp_ff, rsp_in;

   assign advance   = !(s3_valid_ff && (s3_ff.last || s3_ff.empty) &&
                        rsp_valid_ff && !rsp_ready);
   assign req_ready = advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------- step 1
   // relative coordinates and squared distance
   logic signed [REL_BITS-1:0] rel_x, rel_y;
   logic [MAG_BITS-1:0]        mag_x, mag_y;
   logic [SQ_BITS-1:0]         sq_x, sq_y;
   pipct_pkg::rel_type         rel;

   assign rel_x = REL_BITS'($signed(s1_ff.vertex_x)) - REL_BITS'($signed(s1_ff.query_x));
   assign rel_y = REL_BITS'($signed(s1_ff.vertex_y)) - REL_BITS'($signed(s1_ff.query_y));
   assign mag_x = MAG_BITS'(mag_of(rel_x));
   assign mag_y = MAG_BITS'(mag_of(rel_y));
   assign sq_x  = SQ_BITS'(mag_x[NEAR_BITS-1:0]) * SQ_BITS'(mag_x[NEAR_BITS-1:0]);
   assign sq_y  = SQ_BITS'(mag_y[NEAR_BITS-1:0]) * SQ_BITS'(mag_y[NEAR_BITS-1:0]);

   always_comb begin
      rel.cx           = rel_x;
      rel.cy           = rel_y;
      rel.dist_sq      = SUM_BITS'(sq_x) + SUM_BITS'(sq_y);
      // squares are only exact below the near range; farther means not near
      rel.out_of_range = ((mag_x >> NEAR_BITS) != '0) || ((mag_y >> NEAR_BITS) != '0);
      rel.last         = s1_ff.last_vertex;
      rel.empty        = s1_ff.empty_polygon;
   end

   // ---------------------------------------------------------------- step 2
   // previous / first vertex tracking and cross products
   logic                       have_ff, have_in;
   logic signed [REL_BITS-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [REL_BITS-1:0] first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic [SUM_BITS-1:0]        prev_dist_ff, prev_dist_in;
   logic                       prev_oor_ff, prev_oor_in;
   logic signed [REL_BITS-1:0] first_sel_x, first_sel_y;
   pipct_pkg::prod_type        prod;

   // a lone first vertex closes onto itself
   assign first_sel_x = have_ff ? first_x_ff : s2_ff.cx;
   assign first_sel_y = have_ff ? first_y_ff : s2_ff.cy;

   always_comb begin
      prod.last              = s2_ff.last;
      prod.empty             = s2_ff.empty;
      prod.has_prev          = have_ff && !s2_ff.empty;
      prod.pp                = prev_x_ff * s2_ff.cy;
      prod.pq                = prev_y_ff * s2_ff.cx;
      prod.fq                = first_sel_x * s2_ff.cy;
      prod.fr                = s2_ff.cx * first_sel_y;
      prod.cy                = s2_ff.cy;
      prod.prev_y            = prev_y_ff;
      prod.first_y           = first_sel_y;
      prod.dist_sq           = s2_ff.dist_sq;
      prod.out_of_range      = s2_ff.out_of_range;
      prod.prev_dist_sq      = prev_dist_ff;
      prod.prev_out_of_range = prev_oor_ff;
   end

   always_comb begin
      have_in      = have_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      prev_dist_in = prev_dist_ff;
      prev_oor_in  = prev_oor_ff;
      first_x_in   = first_x_ff;
      first_y_in   = first_y_ff;
      if (advance && s2_valid_ff) begin
         if (s2_ff.empty || s2_ff.last) begin
            have_in    = 1'b0;
            prev_x_in  = '0;
            prev_y_in  = '0;
            first_x_in = '0;
            first_y_in = '0;
         end else begin
            have_in      = 1'b1;
            prev_x_in    = s2_ff.cx;
            prev_y_in    = s2_ff.cy;
            prev_dist_in = s2_ff.dist_sq;
            prev_oor_in  = s2_ff.out_of_range;
            if (!have_ff) begin
               first_x_in = s2_ff.cx;
               first_y_in = s2_ff.cy;
            end
         end
      end
   end

   // ---------------------------------------------------------------- step 3
   // sign tests, parities, early verdict and response
   logic                        right_ff, right_in, left_ff, left_in;
   logic [2:0]                  early_ff, early_in;
   logic signed [DIFF_BITS-1:0] d_edge, d_wrap;
   logic [1:0]                  x_edge, x_wrap;
   pipct_pkg::rsp_type          result;

   // d_edge: cx*prev_y - prev_x*cy; zero means the pair is collinear with the point
   assign d_edge = DIFF_BITS'(s3_ff.pq) - DIFF_BITS'(s3_ff.pp);
   assign d_wrap = DIFF_BITS'(s3_ff.fq) - DIFF_BITS'(s3_ff.fr);
   assign x_edge = crossings(d_edge, s3_ff.prev_y, s3_ff.cy);
   assign x_wrap = crossings(d_wrap, s3_ff.cy, s3_ff.first_y);

   always_comb begin
      logic [2:0] code;
      logic       rp, lp;
      code = early_ff;
      rp   = right_ff;
      lp   = left_ff;
      if (s3_ff.has_prev) begin
         if (code == pipct_pkg::EARLY_NONE && d_edge == '0) begin
            code = pipct_pkg::VERDICT_DEGENERATE;
         end
         if (code == pipct_pkg::EARLY_NONE &&
             near_hit(s3_ff.prev_dist_sq, s3_ff.prev_out_of_range, near_ff)) begin
            code = pipct_pkg::VERDICT_NEAR;
         end
         rp = rp ^ x_edge[1];
         lp = lp ^ x_edge[0];
      end
      if (s3_ff.last) begin
         if (code == pipct_pkg::EARLY_NONE &&
             near_hit(s3_ff.dist_sq, s3_ff.out_of_range, near_ff)) begin
            code = pipct_pkg::VERDICT_NEAR;
         end
         rp = rp ^ x_wrap[1];
         lp = lp ^ x_wrap[0];
      end

      if (s3_ff.empty) begin
         result.inside_res = 1'b0;
         result.verdict    = pipct_pkg::VERDICT_DEGENERATE;
      end else if (code != pipct_pkg::EARLY_NONE) begin
         result.inside_res = (code == pipct_pkg::VERDICT_NEAR);
         result.verdict    = code;
      end else if (rp != lp) begin
         result.inside_res = 1'b1;
         result.verdict    = pipct_pkg::VERDICT_EDGE;
      end else if (rp) begin
         result.inside_res = 1'b1;
         result.verdict    = pipct_pkg::VERDICT_ODD;
      end else begin
         result.inside_res = 1'b0;
         result.verdict    = pipct_pkg::VERDICT_EVEN;
      end

      early_in = early_ff;
      right_in = right_ff;
      left_in  = left_ff;
      if (advance && s3_valid_ff) begin
         if (s3_ff.empty || s3_ff.last) begin
            early_in = pipct_pkg::EARLY_NONE;
            right_in = 1'b0;
            left_in  = 1'b0;
         end else begin
            early_in = code;
            right_in = rp;
            left_in  = lp;
         end
      end
   end

   // ---------------------------------------------------------------- stage moves
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s2_valid_in  = s2_valid_ff;
      s3_valid_in  = s3_valid_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      s3_in        = s3_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         s1_valid_in = req_valid;
         s2_valid_in = s1_valid_ff;
         s3_valid_in = s2_valid_ff;
         s1_in       = req_data;
         s2_in       = rel;
         s3_in       = prod;
      end
      if (advance && s3_valid_ff && (s3_ff.last || s3_ff.empty)) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and polygon state
   always_ff @(posedge clock) begin
      if (reset) begin
         near_ff      <= pipct_pkg::NEAR_SQ_RESET;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         have_ff      <= 1'b0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         first_x_ff   <= '0;
         first_y_ff   <= '0;
         right_ff     <= 1'b0;
         left_ff      <= 1'b0;
         early_ff     <= pipct_pkg::EARLY_NONE;
      end else begin
         near_ff      <= near_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         have_ff      <= have_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         first_x_ff   <= first_x_in;
         first_y_ff   <= first_y_in;
         right_ff     <= right_in;
         left_ff      <= left_in;
         early_ff     <= early_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      s1_ff        <= s1_in;
      s2_ff        <= s2_in;
      s3_ff        <= s3_in;
      rsp_ff       <= rsp_in;
      prev_dist_ff <= prev_dist_in;
      prev_oor_ff  <= prev_oor_in;
   end

endmodule

/* sim/tb.sv */
// Self-checking testbench for the point-in-polygon crossing test block.
`timescale 1ns / 1ps

module tb;

   localparam int     COORD_BITS      = pipct_pkg::COORD_BITS;
   localparam int     REL_BITS        = pipct_pkg::REL_BITS;
   localparam int     NEAR_SQ_BITS    = pipct_pkg::NEAR_SQ_BITS;
   localparam int     CSR_ADDR_BITS   = pipct_pkg::CSR_ADDR_BITS;
   localparam int     CSR_DATA_BITS   = pipct_pkg::CSR_DATA_BITS;
   localparam int     CLK_PERIOD      = 10;
   localparam int     DRAIN_CYCLES    = 12;         // response passes s1_ff, s2_ff, s3_ff and rsp_ff after its request
   localparam int     RSP_HOLD_CYCLES = 120;        // long receiver hold-off, fills the pipe
   localparam int     PHASE_REQUESTS  = 165;
   localparam int     PRESSURE_BURST  = 40;
   localparam int     MAX_PRINTS      = 50;
   localparam longint COORD_MAX       = (longint'(1) << (COORD_BITS - 1)) - 1;
   localparam longint COORD_MIN       = -COORD_MAX - 1;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   pipct_pkg::req_type       req_data;
   logic                     rsp_valid;
   logic                     rsp_ready;
   pipct_pkg::rsp_type       rsp_data;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   point_in_polygon_crossing_test_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------
   // Shadow of the polygon tracker: tolerance register plus the running
   // polygon state, all at the block's widths.
   // ------------------------------------------------------------------
   logic [NEAR_SQ_BITS-1:0]    tolerance_sq;
   logic signed [REL_BITS-1:0] first_x, first_y, prev_x, prev_y;
   logic                       right_odd, left_odd, seen_vertex;
   logic [2:0]                 early;

   // expected responses, oldest first
   pipct_pkg::rsp_type expected_rsp[$];

   // run bookkeeping
   int  mismatch_count;
   int  requests_sent;
   int  responses_seen;
   int  verdict_seen[8];
   bit  idle_on;
   bit  stall_on;
   bit  rsp_hold_pending;

   typedef struct {
      pipct_pkg::req_type req;
      bit                 typed;
      pipct_pkg::rsp_type want;
   } vector_row_type;

   vector_row_type directed_rows[$];

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTS) begin
         $display("ERROR @%0t: %s", $realtime, msg);
      end
   endtask

   function automatic void clear_polygon();
      first_x     = '0;
      first_y     = '0;
      prev_x      = '0;
      prev_y      = '0;
      right_odd   = 1'b0;
      left_odd    = 1'b0;
      seen_vertex = 1'b0;
      early       = pipct_pkg::EARLY_NONE;
   endfunction

   // sign of a*b - c*d; relative coordinates are 25 bits so 64 bits are exact
   function automatic int product_sign(input longint a, input longint b,
                                       input longint c, input longint d);
      longint diff;
      diff = a * b - c * d;
      return (diff > 0) ? 1 : ((diff < 0) ? -1 : 0);
   endfunction

   function automatic bit near_query(input longint dx, input longint dy);
      longint mx, my;
      mx = (dx < 0) ? -dx : dx;
      my = (dy < 0) ? -dy : dy;
      if (mx >= (longint'(1) << 24) || my >= (longint'(1) << 24)) return 1'b0;
      return (mx * mx + my * my) < longint'(tolerance_sq);
   endfunction

   // edge a -> b against the horizontal rays from the query point
   function automatic void cross_edge(input longint ax, input longint ay,
                                      input longint bx, input longint by);
      int sn, sd;
      sn = product_sign(bx, ay, ax, by);
      sd = (ay - by > 0) ? 1 : -1;
      if (((by > 0) != (ay > 0)) && (sn == 0 || sn == sd)) right_odd = ~right_odd;
      if (((by < 0) != (ay < 0)) && (sn == 0 || sn != sd)) left_odd = ~left_odd;
   endfunction

   // advance the shadow by one request; returns 1 when a response is due
   function automatic bit track_vertex(input pipct_pkg::req_type r,
                                       output pipct_pkg::rsp_type verdict_out);
      longint cx, cy, px, py;
      verdict_out = '0;
      if (r.empty_polygon) begin
         clear_polygon();
         verdict_out.inside_res = 1'b0;
         verdict_out.verdict    = pipct_pkg::VERDICT_DEGENERATE;
         return 1'b1;
      end
      cx = longint'($signed(r.vertex_x)) - longint'($signed(r.query_x));
      cy = longint'($signed(r.vertex_y)) - longint'($signed(r.query_y));
      px = longint'(prev_x);
      py = longint'(prev_y);
      if (!seen_vertex) begin
         first_x     = REL_BITS'(cx);
         first_y     = REL_BITS'(cy);
         seen_vertex = 1'b1;
      end else begin
         // pair check first, then the near check of the previous vertex
         if (early == pipct_pkg::EARLY_NONE && product_sign(px, cy, py, cx) == 0)
            early = pipct_pkg::VERDICT_DEGENERATE;
         if (early == pipct_pkg::EARLY_NONE && near_query(px, py))
            early = pipct_pkg::VERDICT_NEAR;
         cross_edge(px, py, cx, cy);
      end
      prev_x = REL_BITS'(cx);
      prev_y = REL_BITS'(cy);
      if (!r.last_vertex) return 1'b0;

      if (early == pipct_pkg::EARLY_NONE && near_query(cx, cy)) early = pipct_pkg::VERDICT_NEAR;
      cross_edge(cx, cy, longint'(first_x), longint'(first_y));   // wrap edge
      if (early != pipct_pkg::EARLY_NONE) begin
         verdict_out.inside_res = (early == pipct_pkg::VERDICT_NEAR);
         verdict_out.verdict    = early;
      end else if (right_odd != left_odd) begin
         verdict_out.inside_res = 1'b1;
         verdict_out.verdict    = pipct_pkg::VERDICT_EDGE;
      end else if (right_odd) begin
         verdict_out.inside_res = 1'b1;
         verdict_out.verdict    = pipct_pkg::VERDICT_ODD;
      end else begin
         verdict_out.inside_res = 1'b0;
         verdict_out.verdict    = pipct_pkg::VERDICT_EVEN;
      end
      clear_polygon();
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic logic signed [COORD_BITS-1:0] clamp_coord(input longint v);
      if (v > COORD_MAX) return COORD_BITS'(COORD_MAX);
      if (v < COORD_MIN) return COORD_BITS'(COORD_MIN);
      return COORD_BITS'(v);
   endfunction

   // full-range coordinate, extremes now and then
   function automatic longint rand_coord();
      logic signed [COORD_BITS-1:0] v;
      case ($urandom_range(0, 15))
         0:       v = COORD_BITS'(COORD_MAX);
         1:       v = COORD_BITS'(COORD_MIN);
         default: v = COORD_BITS'($urandom);
      endcase
      return longint'(v);
   endfunction

   function automatic longint rand_offset(input longint span);
      return longint'($urandom_range(0, 32'(2 * span))) - span;
   endfunction

   function automatic void queue_vector(input longint vx, input longint vy,
                                        input longint qx, input longint qy,
                                        input bit last, input bit empty,
                                        input bit typed, input logic want_inside,
                                        input logic [2:0] verdict);
      vector_row_type row;
      row.req                 = '0;
      row.req.vertex_x        = COORD_BITS'(vx);
      row.req.vertex_y        = COORD_BITS'(vy);
      row.req.query_x         = COORD_BITS'(qx);
      row.req.query_y         = COORD_BITS'(qy);
      row.req.last_vertex     = last;
      row.req.empty_polygon   = empty;
      row.typed               = typed;
      row.want.inside_res     = want_inside;
      row.want.verdict        = verdict;
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   // Offer one request; starts and ends at a falling edge. Valid stays up
   // after acceptance so back-to-back requests need no second assignment.
   task automatic send_request(input pipct_pkg::req_type r, input bit typed,
                               input pipct_pkg::rsp_type want);
      pipct_pkg::rsp_type predicted;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = r;
      do @(posedge clock); while (!req_ready);
      if (track_vertex(r, predicted))
         expected_rsp.insert(expected_rsp.size(), typed ? want : predicted);
      requests_sent++;
      @(negedge clock);
   endtask

   // One random polygon around one query point. Mostly well formed; some
   // vertices land on the query point, on its ray, next to it, or on the
   // line through the previous vertex. A few requests carry a moved query
   // point or break the polygon with an empty request.
   task automatic send_polygon();
      int unsigned        count, span_sel, kind;
      longint             span, qx, qy, rx, ry, px, py, k;
      pipct_pkg::req_type r;
      count    = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
      span_sel = $urandom_range(0, 3);
      case (span_sel)
         0:       span = 16;
         1:       span = 1024;
         2:       span = longint'(1) << 18;
         default: span = longint'(1) << 23;
      endcase
      qx = rand_coord();
      qy = rand_coord();
      px = 0;
      py = 0;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(0, 99);
         r    = '0;
         if (kind < 4) begin
            rx = 0;
            ry = 0;
         end else if (kind < 10 && i > 0) begin
            case ($urandom_range(0, 2))
               0:       k = -3;
               1:       k = -1;
               default: k = 2;
            endcase
            rx = px * k;
            ry = py * k;
         end else if (kind < 17) begin
            rx = rand_offset(span);
            ry = 0;
         end else if (kind < 22) begin
            rx = rand_offset(3);
            ry = rand_offset(3);
         end else if (span_sel == 3) begin
            rx = rand_coord() - qx;
            ry = rand_coord() - qy;
         end else begin
            rx = rand_offset(span);
            ry = rand_offset(span);
         end
         r.vertex_x    = clamp_coord(qx + rx);
         r.vertex_y    = clamp_coord(qy + ry);
         r.query_x     = COORD_BITS'(qx);
         r.query_y     = COORD_BITS'(qy);
         r.last_vertex = (i == count - 1);
         if ($urandom_range(0, 32) == 0) begin
            r.query_x = COORD_BITS'(rand_coord());
            r.query_y = COORD_BITS'(rand_coord());
         end
         if (i != count - 1 && $urandom_range(0, 49) == 0) begin
            r.empty_polygon = 1'b1;
            r.last_vertex   = 1'($urandom_range(0, 1));
         end
         send_request(r, 1'b0, '0);
         px = rx;
         py = ry;
      end
   endtask

   // stand-alone request that produces a response: empty, or one lone vertex
   function automatic pipct_pkg::req_type lone_request(input bit empty);
      pipct_pkg::req_type r;
      r.vertex_x      = COORD_BITS'(rand_coord());
      r.vertex_y      = COORD_BITS'(rand_coord());
      r.query_x       = COORD_BITS'(rand_coord());
      r.query_y       = COORD_BITS'(rand_coord());
      r.last_vertex   = empty ? 1'($urandom_range(0, 1)) : 1'b1;
      r.empty_polygon = empty;
      return r;
   endfunction

   // one APB transfer to the tolerance register; starts and ends at a falling edge
   task automatic csr_cycle(input bit is_write, input logic [CSR_DATA_BITS-1:0] wdata,
                            output logic [CSR_DATA_BITS-1:0] rdata);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = is_write;
      csr_paddr   = {pipct_pkg::CSR_IDX_NEAR, 3'b000};
      csr_pwdata  = wdata;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic set_tolerance(input logic [NEAR_SQ_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] readback;
      csr_cycle(1'b1, CSR_DATA_BITS'(value), readback);
      tolerance_sq = value;
      @(negedge clock);
      csr_cycle(1'b0, '0, readback);
      if (readback[NEAR_SQ_BITS-1:0] !== value)
         report_mismatch($sformatf("tolerance readback %h, wrote %h",
                                   readback[NEAR_SQ_BITS-1:0], value));
   endtask

   // wait out every outstanding response, then let the pipe settle
   task automatic drain_pipe();
      req_valid = 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // Receiver: random stall bursts, plus one long hold-off on request
   // from the stimulus thread. The hold is counted here, not by the sender.
   // ------------------------------------------------------------------
   initial begin : rsp_sink
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_pending) begin
            rsp_ready = 1'b0;
            repeat (RSP_HOLD_CYCLES - 1) @(negedge clock);
            rsp_hold_pending = 1'b0;
         end else if (stall_on && $urandom_range(0, 4) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Response checker: every accepted response against the oldest
   // expectation, field by field.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : rsp_check
      pipct_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         responses_seen++;
         verdict_seen[rsp_data.verdict]++;
         if (expected_rsp.size() == 0) begin
            report_mismatch($sformatf("response %0d (inside %b verdict %0d) with none pending",
                                      responses_seen, rsp_data.inside_res, rsp_data.verdict));
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.inside_res !== want.inside_res)
               report_mismatch($sformatf("response %0d inside_res %b, want %b",
                                         responses_seen, rsp_data.inside_res,
                                         want.inside_res));
            if (rsp_data.verdict !== want.verdict)
               report_mismatch($sformatf("response %0d verdict %0d, want %0d",
                                         responses_seen, rsp_data.verdict, want.verdict));
         end
      end
   end

   // hard stop in case the handshakes hang
   initial begin : watchdog
      #(2_000_000);
      $display("FAIL point_in_polygon_crossing_test_top");
      $finish;
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin : stimulus
      logic [CSR_DATA_BITS-1:0] readback;
      logic [NEAR_SQ_BITS-1:0]  tolerances[5];
      int                       phase_start;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      idle_on          = 1'b1;
      stall_on         = 1'b1;
      rsp_hold_pending = 1'b0;
      mismatch_count   = 0;
      requests_sent    = 0;
      responses_seen   = 0;
      tolerance_sq     = pipct_pkg::NEAR_SQ_RESET;
      clear_polygon();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // register must come out of reset at its documented value
      csr_cycle(1'b0, '0, readback);
      if (readback[NEAR_SQ_BITS-1:0] !== pipct_pkg::NEAR_SQ_RESET)
         report_mismatch($sformatf("tolerance after reset %h", readback[NEAR_SQ_BITS-1:0]));
      @(negedge clock);

      // Directed table, run at the reset tolerance (only an exact hit is near).
      // empty polygon ignores the coordinates
      queue_vector(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 0, 1,
                   1, 1'b0, pipct_pkg::VERDICT_DEGENERATE);
      // single vertex on the query point
      queue_vector(5, 7, 5, 7, 1, 0, 1, 1'b1, pipct_pkg::VERDICT_NEAR);
      // single vertex far away, extreme coordinates
      queue_vector(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 1, 0,
                   1, 1'b0, pipct_pkg::VERDICT_EVEN);
      // square around the query point
      queue_vector(200, -300, 300, -200, 0, 0, 0, 1'b0, pipct_pkg::VERDICT_EVEN);
      queue_vector(400, -300, 300, -200, 0, 0, 0, 1'b0, pipct_pkg::VERDICT_EVEN);
      queue_vector(400, -100, 300, -200, 0, 0, 0, 1'b0, pipct_pkg::VERDICT_EVEN);
      queue_vector(200, -100, 300, -200, 1, 0, 0, 1'b0, pipct_pkg::VERDICT_EVEN);
      // first pair lies on a line through the query point
      queue_vector(10, 10, 0, 0, 0, 0, 0, 1'b0, pipct_pkg::VERDICT_EVEN);
      queue_vector(-20, -20, 0, 0, 0, 0, 0, 1'b0, pipct_pkg::VERDICT_EVEN);
      queue_vector(30, -5, 0, 0, 1, 0, 0, 1'b0, pipct_pkg::VERDICT_EVEN);
      // unfinished polygon dropped by an empty request
      queue_vector(1, 2, 0, 0, 0, 0, 0, 1'b0, pipct_pkg::VERDICT_EVEN);
      queue_vector(50, 60, 0, 0, 0, 0, 0, 1'b0, pipct_pkg::VERDICT_EVEN);
      queue_vector(0, 0, 0, 0, 1, 1, 1, 1'b0, pipct_pkg::VERDICT_DEGENERATE);
      // corners of the coordinate range, query point moving mid polygon
      queue_vector(COORD_MAX, COORD_MAX, 0, 0, 0, 0, 0, 1'b0, pipct_pkg::VERDICT_EVEN);
      queue_vector(COORD_MIN, COORD_MAX, 0, 0, 0, 0, 0, 1'b0, pipct_pkg::VERDICT_EVEN);
      queue_vector(COORD_MIN, COORD_MIN, -1, 1, 0, 0, 0, 1'b0, pipct_pkg::VERDICT_EVEN);
      queue_vector(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 1, 0,
                   0, 1'b0, pipct_pkg::VERDICT_EVEN);
      // query point on the unchecked wrap edge: parities differ
      queue_vector(900, -1000, 1000, -1000, 0, 0, 0, 1'b0, pipct_pkg::VERDICT_EVEN);
      queue_vector(1000, -900, 1000, -1000, 0, 0, 0, 1'b0, pipct_pkg::VERDICT_EVEN);
      queue_vector(1100, -1000, 1000, -1000, 1, 0, 0, 1'b0, pipct_pkg::VERDICT_EVEN);
      // last and empty together: empty wins
      queue_vector(3, 4, 3, 4, 1, 1, 1, 1'b0, pipct_pkg::VERDICT_DEGENERATE);
      // diamond with every vertex on an axis through the query point
      queue_vector(50, 0, 0, 0, 0, 0, 0, 1'b0, pipct_pkg::VERDICT_EVEN);
      queue_vector(0, 50, 0, 0, 0, 0, 0, 1'b0, pipct_pkg::VERDICT_EVEN);
      queue_vector(-50, 0, 0, 0, 0, 0, 0, 1'b0, pipct_pkg::VERDICT_EVEN);
      queue_vector(0, -50, 0, 0, 1, 0, 0, 1'b0, pipct_pkg::VERDICT_EVEN);

      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

      // Random phases, each under its own tolerance; zero and full scale
      // among them. The last phase runs without any idling.
      tolerances[0] = '0;
      tolerances[1] = NEAR_SQ_BITS'(1);
      tolerances[2] = NEAR_SQ_BITS'($urandom_range(2, 65536));
      tolerances[3] = NEAR_SQ_BITS'({8'($urandom_range(1, 255)), 32'($urandom)}) << 4;
      tolerances[4] = '1;

      for (int p = 0; p < 5; p++) begin
         drain_pipe();
         set_tolerance(tolerances[p]);
         idle_on  = (p != 4);
         stall_on = (p != 4);

         // back pressure: receiver holds off while the sender keeps
         // offering lone requests, empty or one vertex, until the block stalls its input
         if (p == 1) begin
            rsp_hold_pending = 1'b1;
            repeat (PRESSURE_BURST)
               send_request(lone_request($urandom_range(0, 3) == 0), 1'b0, '0);
         end

         phase_start = requests_sent;
         while (requests_sent - phase_start < PHASE_REQUESTS) begin
            if ($urandom_range(0, 32) == 0)
               send_request(lone_request(1'b1), 1'b0, '0);
            else
               send_polygon();
         end
      end

      drain_pipe();

      $display("Run covered %0d requests (%0d directed) over 5 tolerance settings, %0d responses",
               requests_sent, directed_rows.size(), responses_seen);
      $display("Verdicts: even %0d, odd %0d, edge %0d, near %0d, degenerate %0d",
               verdict_seen[pipct_pkg::VERDICT_EVEN], verdict_seen[pipct_pkg::VERDICT_ODD],
               verdict_seen[pipct_pkg::VERDICT_EDGE], verdict_seen[pipct_pkg::VERDICT_NEAR],
               verdict_seen[pipct_pkg::VERDICT_DEGENERATE]);
      if (mismatch_count == 0) begin
         $display("PASS point_in_polygon_crossing_test_top");
      end else begin
         $display("FAIL point_in_polygon_crossing_test_top");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/pipct_pkg.sv
rtl/point_in_polygon_crossing_test_top.sv
sim/tb.sv
